// ===== rtl/skvt_pkg.sv =====
// Package for the sorted key/value table: sizes, command codes, shared types.
// No dependencies.
`default_nettype none
package skvt_pkg;
  localparam int Capacity  = 256;
  localparam int KeyBits   = 32;
  localparam int ValueBits = 32;
  localparam int AddrBits  = $clog2(Capacity);
  localparam int CountBits = $clog2(Capacity + 1);
  localparam int EntryBits = KeyBits + ValueBits;

  localparam logic [2:0] CMD_FIND   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_ERASE  = 3'd2;
  localparam logic [2:0] CMD_FETCH  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic                 hit;
    logic [ValueBits-1:0] read_value;
    logic                 changed;
    logic                 full_refused;
    logic [CountBits-1:0] entries_now;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/skvt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module skvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/skvt_engine.sv =====
// Command sequencer: binary search, then a shift-insert or shift-erase if needed.
// Depends on skvt_pkg and skvt_ram.
`default_nettype none
module skvt_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [2:0]                    cmd_in,
  input  wire logic [skvt_pkg::KeyBits-1:0]  key_in,
  input  wire logic [skvt_pkg::ValueBits-1:0] val_in,
  input  wire logic                          out_ready,
  output logic                               busy,
  output logic                               done,
  output skvt_pkg::result_t                  res
);
  localparam int AW = skvt_pkg::AddrBits;
  localparam int CW = skvt_pkg::CountBits;
  localparam int KW = skvt_pkg::KeyBits;
  localparam int VW = skvt_pkg::ValueBits;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_CHK   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic [2:0]    cmd;
  logic [KW-1:0] key;
  logic [VW-1:0] val;
  logic [CW-1:0] count, lo, hi, mid, pos, idx;
  logic          rd_pend;
  logic          insert_mode;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [skvt_pkg::EntryBits-1:0] wdata, rdata;
  logic [KW-1:0] rkey;
  logic [VW-1:0] rval;

  assign rkey = rdata[KW-1:0];
  assign rval = rdata[skvt_pkg::EntryBits-1:KW];
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign mid  = lo + ((hi - lo) >> 1);

  skvt_ram #(.Width(skvt_pkg::EntryBits), .Depth(skvt_pkg::Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Read address: search probe, check read at pos, or source entry of the shift.
  always_comb begin
    raddr = mid[AW-1:0];
    if (state == S_SHIFT) begin
      raddr = insert_mode ? AW'(idx - CW'(1)) : AW'(idx + CW'(1));
    end else if (state == S_CHK) begin
      raddr = pos[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd     <= cmd_in;
            key     <= key_in;
            val     <= val_in;
            lo      <= '0;
            hi      <= count;
            rd_pend <= 1'b0;
            state   <= S_SRCH;
          end
        end
        S_SRCH: begin
          // Each probe: issue read, then compare.
          if (!rd_pend) begin
            if (lo == hi) begin
              pos   <= lo;
              state <= S_CHK;
            end else begin
              rd_pend <= 1'b1;
            end
          end else begin
            rd_pend <= 1'b0;
            if (rkey < key) lo <= mid + CW'(1);
            else            hi <= mid;
          end
        end
        S_CHK: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            res.hit          <= (pos < count) && (rkey == key);
            res.read_value   <= '0;
            res.changed      <= 1'b0;
            res.full_refused <= 1'b0;
            res.entries_now  <= count;
            state            <= S_DONE;
            if (cmd == skvt_pkg::CMD_INSERT || cmd == skvt_pkg::CMD_FETCH) begin
              if ((pos < count) && (rkey == key)) begin
                res.read_value <= rval;
              end else if (count >= CW'(skvt_pkg::Capacity)) begin
                res.full_refused <= 1'b1;
              end else begin
                if (cmd == skvt_pkg::CMD_FETCH) val <= '0;
                res.read_value  <= (cmd == skvt_pkg::CMD_FETCH) ? '0 : val;
                res.changed     <= 1'b1;
                res.entries_now <= count + CW'(1);
                insert_mode     <= 1'b1;
                idx             <= count;
                state           <= (count == pos) ? S_WRITE : S_SHIFT;
              end
            end else if (cmd == skvt_pkg::CMD_ERASE) begin
              if ((pos < count) && (rkey == key)) begin
                res.changed     <= 1'b1;
                res.entries_now <= count - CW'(1);
                insert_mode     <= 1'b0;
                idx             <= pos;
                state           <= (pos + CW'(1) == count) ? S_WRITE : S_SHIFT;
              end
            end else if (cmd == skvt_pkg::CMD_CLEAR) begin
              res.changed     <= (count != '0);
              res.entries_now <= '0;
              count           <= '0;
            end else if ((pos < count) && (rkey == key)) begin
              res.read_value <= rval;
            end
          end
        end
        S_SHIFT: begin
          // Move one entry toward idx: read it, then write it at idx.
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            we      <= 1'b1;
            waddr   <= idx[AW-1:0];
            wdata   <= rdata;
            if (insert_mode) begin
              idx <= idx - CW'(1);
              if (idx - CW'(1) == pos) state <= S_WRITE;
            end else begin
              idx <= idx + CW'(1);
              if (idx + CW'(2) == count) state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (insert_mode) begin
            we    <= 1'b1;
            waddr <= pos[AW-1:0];
            wdata <= {val, key};
            count <= count + CW'(1);
          end else begin
            count <= count - CW'(1);
          end
          state <= S_DONE;
        end
        // Hold the finished result until the output register can take it.
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sorted_key_value_table_core.sv =====
// Top level of the sorted key/value table: stream ports and output register.
// Depends on skvt_pkg and skvt_engine.
`default_nettype none
// One command at a time. Entries sit sorted in one RAM (key and value per
// word, registered read). A command runs a binary search (at most 9
// probes, plus a closing step) and a check read; a command that adds or
// erases an entry then shifts entries one at a time where any must move,
// and passes a write state. Every command ends in a done state, and the
// next word is taken once the engine is idle again. The result waits in
// an output register; the next command is taken while it waits, and a
// finished command holds in its done state while that register is still
// occupied.
module sorted_key_value_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // command[2:0], key[34:3], value[66:35], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata   // hit[0], read_value[32:1], changed[33],
                                     // full_refused[34], entries_now[43:35], zero pad
);
  logic busy, done, start, out_ready;
  skvt_pkg::result_t res;

  assign s_tready  = !busy;
  assign start     = s_tvalid && s_tready;
  assign out_ready = !m_tvalid || m_tready;

  skvt_engine u_engine (
    .clk(clk), .rst(rst), .start(start),
    .cmd_in(s_tdata[2:0]), .key_in(s_tdata[34:3]), .val_in(s_tdata[66:35]),
    .out_ready(out_ready),
    .busy(busy), .done(done), .res(res)
  );

  // Engine stalls in done only if the output word is still held.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (done && out_ready) || (m_tvalid && !m_tready);
      if (done && out_ready) begin
        m_tdata  <= {4'd0, res.entries_now, res.full_refused, res.changed,
                     res.read_value, res.hit};
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for sorted_key_value_table_core: random and directed commands,
// predicted results checked in order. Depends on skvt_pkg and the RTL.
`default_nettype none

class kv_scoreboard;
  bit [31:0] keys[$];
  bit [31:0] vals[$];
  skvt_pkg::result_t pending[$];
  int errors;

  // Predict the result of one accepted command and queue it.
  function void note_command(bit [2:0] cmd, bit [31:0] k, bit [31:0] v);
    skvt_pkg::result_t r;
    int pos;
    bit present;
    pos = 0;
    while (pos < keys.size() && keys[pos] < k) pos++;
    present = pos < keys.size() && keys[pos] == k;
    r = '0;
    r.hit = present;
    case (cmd)
      skvt_pkg::CMD_INSERT, skvt_pkg::CMD_FETCH: begin
        if (present) begin
          r.read_value = vals[pos];
        end else if (keys.size() >= skvt_pkg::Capacity) begin
          r.full_refused = 1'b1;
        end else begin
          r.read_value = (cmd == skvt_pkg::CMD_INSERT) ? v : 32'd0;
          keys.insert(pos, k);
          vals.insert(pos, r.read_value);
          r.changed = 1'b1;
        end
      end
      skvt_pkg::CMD_ERASE: begin
        if (present) begin
          keys.delete(pos);
          vals.delete(pos);
          r.changed = 1'b1;
        end
      end
      skvt_pkg::CMD_CLEAR: begin
        r.changed = keys.size() != 0;
        keys.delete();
        vals.delete();
      end
      default: begin
        if (present) r.read_value = vals[pos];
      end
    endcase
    r.entries_now = skvt_pkg::CountBits'(keys.size());
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(skvt_pkg::result_t got);
    skvt_pkg::result_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.hit != exp.hit) begin
      $display("%0t: hit exp %0d got %0d", $time, exp.hit, got.hit);
      errors++;
    end
    if (got.read_value != exp.read_value) begin
      $display("%0t: read_value exp %h got %h", $time, exp.read_value, got.read_value);
      errors++;
    end
    if (got.changed != exp.changed) begin
      $display("%0t: changed exp %0d got %0d", $time, exp.changed, got.changed);
      errors++;
    end
    if (got.full_refused != exp.full_refused) begin
      $display("%0t: full_refused exp %0d got %0d", $time, exp.full_refused,
               got.full_refused);
      errors++;
    end
    if (got.entries_now != exp.entries_now) begin
      $display("%0t: entries_now exp %0d got %0d", $time, exp.entries_now,
               got.entries_now);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  kv_scoreboard sb = new();
  int  hold_cycles = 0;   // long receiver stall requested by the sender side
  bit [31:0] used_keys[$];

  sorted_key_value_table_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Present one word and wait for acceptance; the predictor sees it on accept.
  // Returns at the falling edge after acceptance with tvalid still up.
  task automatic send_word(bit [2:0] cmd, bit [31:0] k, bit [31:0] v, bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 11) : 0;
    if (wait_n != 0) begin
      s_tvalid <= 1'b0;
      repeat (wait_n) @(negedge clk);
    end
    s_tdata  <= {5'd0, v, k, cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, k, v);
    used_keys.insert(used_keys.size(), k);
    @(negedge clk);
  endtask

  function automatic bit [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return used_keys.size() ? used_keys[$urandom_range(0, used_keys.size() - 1)]
                                       : $urandom_range(0, 40);
    endcase
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus long holds on request.
  initial begin
    int n;
    skvt_pkg::result_t got;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (n != 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.hit          = m_tdata[0];
      got.read_value   = m_tdata[32:1];
      got.changed      = m_tdata[33];
      got.full_refused = m_tdata[34];
      got.entries_now  = m_tdata[43:35];
      sb.check_result(got);
    end
  end

  initial begin
    int i;
    bit [2:0] cmd;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, extremes, every command, unused codes.
    send_word(skvt_pkg::CMD_FIND, 32'd0, 32'd0, 0);
    send_word(skvt_pkg::CMD_ERASE, 32'd5, 32'd0, 0);
    send_word(skvt_pkg::CMD_CLEAR, 32'd0, 32'd0, 0);
    send_word(skvt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(skvt_pkg::CMD_INSERT, 32'd0, 32'h8000_0001, 0);
    send_word(skvt_pkg::CMD_INSERT, 32'h8000_0000, 32'h1234_5678, 0);
    send_word(skvt_pkg::CMD_INSERT, 32'h8000_0000, 32'hDEAD_BEEF, 0);
    send_word(skvt_pkg::CMD_FETCH, 32'h7FFF_FFFF, 32'hAAAA_5555, 0);
    send_word(skvt_pkg::CMD_FETCH, 32'hFFFF_FFFF, 32'd0, 0);
    send_word(3'd5, 32'h8000_0000, 32'd0, 0);
    send_word(3'd6, 32'd0, 32'd0, 0);
    send_word(3'd7, 32'd1, 32'd0, 0);
    send_word(skvt_pkg::CMD_ERASE, 32'h8000_0000, 32'd0, 0);
    send_word(skvt_pkg::CMD_FIND, 32'h8000_0000, 32'd0, 0);
    send_word(skvt_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'd0, 0);
    send_word(skvt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'd0, 0);

    // Fill to capacity under a hold-off stall, then refused additions.
    hold_cycles = 300;
    for (i = 0; i < skvt_pkg::Capacity; i++) begin
      send_word(skvt_pkg::CMD_INSERT, i * 3, $urandom(), 0);
    end
    send_word(skvt_pkg::CMD_INSERT, 32'd1, 32'd9, 0);
    send_word(skvt_pkg::CMD_FETCH, 32'hFFFF_FFFF, 32'd0, 0);
    send_word(skvt_pkg::CMD_INSERT, 32'd3, 32'd9, 0);
    send_word(skvt_pkg::CMD_ERASE, 32'd0, 32'd0, 0);
    send_word(skvt_pkg::CMD_FETCH, 32'd2, 32'd0, 0);
    wait_drained();
    send_word(skvt_pkg::CMD_CLEAR, 32'd0, 32'd0, 0);

    // Random mix, mostly adds and lookups on known keys.
    for (i = 0; i < 420; i++) begin
      case ($urandom_range(0, 19))
        0: cmd = skvt_pkg::CMD_CLEAR;
        1: cmd = 3'($urandom_range(5, 7));
        2, 3, 4, 5, 6, 7: cmd = skvt_pkg::CMD_INSERT;
        8, 9, 10: cmd = skvt_pkg::CMD_FETCH;
        11, 12, 13: cmd = skvt_pkg::CMD_ERASE;
        default: cmd = skvt_pkg::CMD_FIND;
      endcase
      if (cmd == skvt_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0) begin
        cmd = skvt_pkg::CMD_INSERT;
      end
      send_word(cmd, pick_key(), $urandom(), $urandom_range(0, 4) != 0);
      if (i == 210) wait_drained();
    end
    wait_drained();
    repeat (600) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
